/* design/assert_macros.svh */
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every clock edge outside reset
`define ASSERT_ALWAYS(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("%m: assertion failed");

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLIES(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: assertion failed");

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: assertion failed");

`endif

/* design/cir_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cir_pkg
// types, codes and helpers for the interrupt recognition block
// ----------------------------------------------------------------------------
package cir_pkg;

   localparam logic [1:0] FUNC_TICK  = 2'd0;
   localparam logic [1:0] FUNC_CLEAR = 2'd1;
   localparam logic [1:0] FUNC_FORCE = 2'd2;

   localparam logic [1:0] KIND_NONE  = 2'd0;
   localparam logic [1:0] KIND_RESET = 2'd1;
   localparam logic [1:0] KIND_NMI   = 2'd2;
   localparam logic [1:0] KIND_IRQ   = 2'd3;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SYNC  = 3'd1;
   localparam logic [2:0] ST_EDGE  = 3'd2;
   localparam logic [2:0] ST_PEND  = 3'd3;
   localparam logic [2:0] ST_SUBST = 3'd4;

   localparam logic [1:0] PH_T0  = 2'd1;
   localparam logic [1:0] PH_T2  = 2'd2;
   localparam logic [1:0] PH_T1F = 2'd3;

   localparam logic [15:0] VEC_RESET = 16'hFFFC;
   localparam logic [15:0] VEC_NMI   = 16'hFFFA;
   localparam logic [15:0] VEC_IRQ   = 16'hFFFE;
   localparam logic [15:0] VEC_NONE  = 16'h0000;

   typedef struct packed {
      logic [1:0] func;
      logic       nmi_pin_n;
      logic       irq_pin_n;
      logic       reset_pin_n;
      logic [1:0] timing_phase;
      logic       irq_disable;
      logic       branch_now;
      logic       page_cross_now;
      logic [1:0] clear_kind;
   } cir_item_type;

   typedef struct packed {
      logic        vector_ready;
      logic [1:0]  vector_kind;
      logic [15:0] vector_address;
      logic [2:0]  nmi_state;
      logic [2:0]  irq_state;
      logic [2:0]  rst_state;
      logic        intg_level;
      logic        resg_level;
   } cir_result_type;

   typedef struct packed {
      logic [2:0] nmi_state;
      logic [2:0] irq_state;
      logic [2:0] rst_state;
      logic       nmi_prev_asserted;
      logic       nmi_edge_seen;
      logic       nmi_edge_held;
      logic       trigger_at_t0;
      logic       trigger_at_t2;
      logic       substitution_ready;
      logic [1:0] selected_kind;
   } cir_state_type;

   function automatic logic [1:0] top_kind(input logic [2:0] rst_st,
                                           input logic [2:0] nmi_st,
                                           input logic [2:0] irq_st);
      logic [1:0] kind;
      if (rst_st >= ST_PEND) begin
         kind = KIND_RESET;
      end else if (nmi_st >= ST_PEND) begin
         kind = KIND_NMI;
      end else if (irq_st >= ST_PEND) begin
         kind = KIND_IRQ;
      end else begin
         kind = KIND_NONE;
      end
      return kind;
   endfunction

   function automatic logic [15:0] vector_of(input logic [1:0] kind);
      logic [15:0] addr;
      case (kind)
         KIND_RESET: addr = VEC_RESET;
         KIND_NMI:   addr = VEC_NMI;
         KIND_IRQ:   addr = VEC_IRQ;
         default:    addr = VEC_NONE;
      endcase
      return addr;
   endfunction

endpackage
`default_nettype wire

/* design/cpu_interrupt_recognition_top.sv */
// ----------------------------------------------------------------------------
// cpu_interrupt_recognition_top: nmi, irq and reset recognition, one item a cycle unless rsp_stall holds
// an item passes the input register, then the result register loaded with the update
// throughput 1 item per cycle while rsp_stall is low, set by the recognizer state update
// reset is synchronous: all stages idle, pin history and triggers cleared
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module cpu_interrupt_recognition_top
   import cir_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_func,
   input  wire logic        req_nmi_pin_n,
   input  wire logic        req_irq_pin_n,
   input  wire logic        req_reset_pin_n,
   input  wire logic [1:0]  req_timing_phase,
   input  wire logic        req_irq_disable,
   input  wire logic        req_branch_now,
   input  wire logic        req_page_cross_now,
   input  wire logic [1:0]  req_clear_kind,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_vector_ready,
   output logic [1:0]       rsp_vector_kind,
   output logic [15:0]      rsp_vector_address,
   output logic [2:0]       rsp_nmi_stage_now,
   output logic [2:0]       rsp_irq_stage_now,
   output logic [2:0]       rsp_reset_stage_now,
   output logic             rsp_intg_level,
   output logic             rsp_resg_level
);

   logic           in_valid_ff;
   cir_item_type   in_item_ff;
   logic           out_valid_ff;
   cir_result_type out_ff;
   cir_result_type step_result;
   logic           out_free;
   logic           advance;
   logic           req_accept;

   assign out_free   = !out_valid_ff || !rsp_stall;
   assign advance    = in_valid_ff && out_free;
   assign req_stall  = in_valid_ff && !out_free;
   assign req_accept = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_accept) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_item_ff.func           <= req_func;
         in_item_ff.nmi_pin_n      <= req_nmi_pin_n;
         in_item_ff.irq_pin_n      <= req_irq_pin_n;
         in_item_ff.reset_pin_n    <= req_reset_pin_n;
         in_item_ff.timing_phase   <= req_timing_phase;
         in_item_ff.irq_disable    <= req_irq_disable;
         in_item_ff.branch_now     <= req_branch_now;
         in_item_ff.page_cross_now <= req_page_cross_now;
         in_item_ff.clear_kind     <= req_clear_kind;
      end
      if (advance) begin
         out_ff <= step_result;
      end
   end

   cir_engine u_engine (
      .clock  (clock),
      .reset  (reset),
      .apply  (advance),
      .item   (in_item_ff),
      .result (step_result)
   );

   assign rsp_valid           = out_valid_ff;
   assign rsp_vector_ready    = out_ff.vector_ready;
   assign rsp_vector_kind     = out_ff.vector_kind;
   assign rsp_vector_address  = out_ff.vector_address;
   assign rsp_nmi_stage_now   = out_ff.nmi_state;
   assign rsp_irq_stage_now   = out_ff.irq_state;
   assign rsp_reset_stage_now = out_ff.rst_state;
   assign rsp_intg_level      = out_ff.intg_level;
   assign rsp_resg_level      = out_ff.resg_level;

   `ASSERT_NEXT(a_stalled_item_kept, clock, reset, in_valid_ff && !out_free,
                in_valid_ff && $stable(in_item_ff))
   `ASSERT_NEXT(a_advance_shows, clock, reset, advance, out_valid_ff)

endmodule
`default_nettype wire

/* design/cir_engine.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cir_engine
// recognizer state and its one-item update for nmi, irq and reset
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cir_engine
   import cir_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           apply,
   input  wire cir_item_type   item,
   output cir_result_type      result
);

   cir_state_type state_ff;
   cir_state_type state_in;

   logic       nmi_a;
   logic       irq_a;
   logic       rst_a;
   logic       fire;
   logic [1:0] top;

   always_comb begin
      state_in = state_ff;
      nmi_a = ~item.nmi_pin_n;
      irq_a = ~item.irq_pin_n;
      rst_a = ~item.reset_pin_n;
      fire  = 1'b0;
      top   = KIND_NONE;
      case (item.func)
         FUNC_TICK: begin
            // pin sampling and nmi assertion edge
            if (!state_in.nmi_prev_asserted && nmi_a) begin
               state_in.nmi_edge_seen = 1'b1;
            end
            state_in.nmi_prev_asserted = nmi_a;
            if (nmi_a && state_in.nmi_state == ST_IDLE) begin
               state_in.nmi_state = ST_SYNC;
            end
            if (irq_a && state_in.irq_state == ST_IDLE) begin
               state_in.irq_state = ST_SYNC;
            end
            if (rst_a && state_in.rst_state == ST_IDLE) begin
               state_in.rst_state = ST_SYNC;
            end
            // stage 1
            if (state_in.nmi_state == ST_SYNC && state_in.nmi_edge_seen) begin
               state_in.nmi_state     = ST_EDGE;
               state_in.nmi_edge_held = 1'b1;
               state_in.nmi_edge_seen = 1'b0;
            end
            if (state_in.irq_state == ST_SYNC) begin
               state_in.irq_state = (irq_a && !item.irq_disable) ? ST_EDGE : ST_IDLE;
            end
            if (state_in.rst_state == ST_SYNC && rst_a) begin
               state_in.rst_state = ST_EDGE;
            end
            // stage 2
            fire = (state_ff.trigger_at_t0 && item.timing_phase == PH_T0) ||
                   (state_ff.trigger_at_t2 && item.timing_phase == PH_T2);
            if (fire) begin
               if (state_in.nmi_state == ST_EDGE && state_in.nmi_edge_held) begin
                  state_in.nmi_state = ST_PEND;
               end
               if (state_in.irq_state == ST_EDGE && !item.irq_disable) begin
                  state_in.irq_state = ST_PEND;
               end
               if (state_in.rst_state == ST_EDGE) begin
                  state_in.rst_state = ST_PEND;
               end
            end
            // stage 3
            if (item.timing_phase == PH_T1F) begin
               top = top_kind(state_in.rst_state, state_in.nmi_state,
                              state_in.irq_state);
               if (top == KIND_RESET && state_in.rst_state == ST_PEND) begin
                  state_in.rst_state          = ST_SUBST;
                  state_in.selected_kind      = KIND_RESET;
                  state_in.substitution_ready = 1'b1;
               end else if (top == KIND_NMI && state_in.nmi_state == ST_PEND) begin
                  state_in.nmi_state          = ST_SUBST;
                  state_in.selected_kind      = KIND_NMI;
                  state_in.substitution_ready = 1'b1;
               end else if (top == KIND_IRQ && state_in.irq_state == ST_PEND) begin
                  state_in.irq_state          = ST_SUBST;
                  state_in.selected_kind      = KIND_IRQ;
                  state_in.substitution_ready = 1'b1;
               end
            end
            // demote lower priority substitutions
            top = top_kind(state_in.rst_state, state_in.nmi_state, state_in.irq_state);
            if (top != KIND_IRQ && state_in.irq_state == ST_SUBST) begin
               state_in.irq_state = ST_PEND;
            end
            if (top != KIND_NMI && state_in.nmi_state == ST_SUBST) begin
               state_in.nmi_state = ST_PEND;
            end
            // trigger for the next tick
            state_in.trigger_at_t2 = item.branch_now && !item.page_cross_now;
            state_in.trigger_at_t0 = !state_in.trigger_at_t2;
         end
         FUNC_CLEAR: begin
            case (item.clear_kind)
               KIND_RESET: state_in.rst_state = ST_IDLE;
               KIND_NMI: begin
                  state_in.nmi_state     = ST_IDLE;
                  state_in.nmi_edge_held = 1'b0;
                  state_in.nmi_edge_seen = 1'b0;
               end
               KIND_IRQ: state_in.irq_state = ST_IDLE;
               default: ;
            endcase
            state_in.substitution_ready = 1'b0;
            state_in.selected_kind      = KIND_NONE;
         end
         FUNC_FORCE: begin
            state_in.nmi_state          = ST_IDLE;
            state_in.irq_state          = ST_IDLE;
            state_in.rst_state          = ST_SUBST;
            state_in.nmi_edge_seen      = 1'b0;
            state_in.nmi_edge_held      = 1'b0;
            state_in.selected_kind      = KIND_RESET;
            state_in.substitution_ready = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (apply) begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      result.vector_ready   = state_in.substitution_ready;
      result.vector_kind    = state_in.selected_kind;
      result.vector_address = vector_of(state_in.selected_kind);
      result.nmi_state      = state_in.nmi_state;
      result.irq_state      = state_in.irq_state;
      result.rst_state      = state_in.rst_state;
      result.intg_level     = (state_in.nmi_state >= ST_PEND) ||
                              (state_in.irq_state >= ST_PEND);
      result.resg_level     = state_in.rst_state >= ST_PEND;
   end

   `ASSERT_ALWAYS(a_ready_kind, clock, reset,
                  state_ff.substitution_ready == (state_ff.selected_kind != KIND_NONE))
   `ASSERT_NEXT(a_force_reset, clock, reset, apply && item.func == FUNC_FORCE,
                state_ff.rst_state == ST_SUBST && state_ff.nmi_state == ST_IDLE &&
                state_ff.irq_state == ST_IDLE)
   `ASSERT_NEXT(a_hold_idle, clock, reset, !apply, $stable(state_ff))

endmodule
`default_nettype wire

/* tb/recognition_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// recognition_checker
// watches both channels of the interrupt recognition block, keeps its own
// copy of the nmi, irq and reset recognizers, predicts the report of every
// accepted item and compares it field by field with the report that comes out
// ----------------------------------------------------------------------------
module recognition_checker
   import cir_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [1:0]  req_func,
   input  logic        req_nmi_pin_n,
   input  logic        req_irq_pin_n,
   input  logic        req_reset_pin_n,
   input  logic [1:0]  req_timing_phase,
   input  logic        req_irq_disable,
   input  logic        req_branch_now,
   input  logic        req_page_cross_now,
   input  logic [1:0]  req_clear_kind,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic        rsp_vector_ready,
   input  logic [1:0]  rsp_vector_kind,
   input  logic [15:0] rsp_vector_address,
   input  logic [2:0]  rsp_nmi_stage_now,
   input  logic [2:0]  rsp_irq_stage_now,
   input  logic [2:0]  rsp_reset_stage_now,
   input  logic        rsp_intg_level,
   input  logic        rsp_resg_level,
   output int          mismatch_count,
   output int          reports_pending
);

   cir_state_type  shadow;
   cir_result_type predicted_reports[$];
   cir_item_type   incoming;
   cir_result_type wanted;

   initial begin
      shadow = '0;
      mismatch_count = 0;
      reports_pending = 0;
   end

   function automatic logic [1:0] leading_kind(input cir_state_type s);
      if (s.rst_state >= ST_PEND) return KIND_RESET;
      if (s.nmi_state >= ST_PEND) return KIND_NMI;
      if (s.irq_state >= ST_PEND) return KIND_IRQ;
      return KIND_NONE;
   endfunction

   function automatic void clock_recognizers(input cir_item_type it);
      logic       nmi_on;
      logic       irq_on;
      logic       rst_on;
      logic       fire;
      logic [1:0] lead;
      nmi_on = !it.nmi_pin_n;
      irq_on = !it.irq_pin_n;
      rst_on = !it.reset_pin_n;

      // pin sampling, nmi is latched on assertion
      if (!shadow.nmi_prev_asserted && nmi_on) shadow.nmi_edge_seen = 1'b1;
      shadow.nmi_prev_asserted = nmi_on;
      if (nmi_on && shadow.nmi_state == ST_IDLE) shadow.nmi_state = ST_SYNC;
      if (irq_on && shadow.irq_state == ST_IDLE) shadow.irq_state = ST_SYNC;
      if (rst_on && shadow.rst_state == ST_IDLE) shadow.rst_state = ST_SYNC;

      if (shadow.nmi_state == ST_SYNC && shadow.nmi_edge_seen) begin
         shadow.nmi_state = ST_EDGE;
         shadow.nmi_edge_held = 1'b1;
         shadow.nmi_edge_seen = 1'b0;
      end
      if (shadow.irq_state == ST_SYNC) begin
         shadow.irq_state = (irq_on && !it.irq_disable) ? ST_EDGE : ST_IDLE;
      end
      if (shadow.rst_state == ST_SYNC && rst_on) shadow.rst_state = ST_EDGE;

      fire = (shadow.trigger_at_t0 && it.timing_phase == PH_T0) ||
             (shadow.trigger_at_t2 && it.timing_phase == PH_T2);
      if (fire) begin
         if (shadow.nmi_state == ST_EDGE && shadow.nmi_edge_held) shadow.nmi_state = ST_PEND;
         if (shadow.irq_state == ST_EDGE && !it.irq_disable) shadow.irq_state = ST_PEND;
         if (shadow.rst_state == ST_EDGE) shadow.rst_state = ST_PEND;
      end

      if (it.timing_phase == PH_T1F) begin
         lead = leading_kind(shadow);
         if (lead == KIND_RESET && shadow.rst_state == ST_PEND) begin
            shadow.rst_state = ST_SUBST;
            shadow.selected_kind = KIND_RESET;
            shadow.substitution_ready = 1'b1;
         end else if (lead == KIND_NMI && shadow.nmi_state == ST_PEND) begin
            shadow.nmi_state = ST_SUBST;
            shadow.selected_kind = KIND_NMI;
            shadow.substitution_ready = 1'b1;
         end else if (lead == KIND_IRQ && shadow.irq_state == ST_PEND) begin
            shadow.irq_state = ST_SUBST;
            shadow.selected_kind = KIND_IRQ;
            shadow.substitution_ready = 1'b1;
         end
      end

      // lower priority substitutions fall back to pending
      lead = leading_kind(shadow);
      if (lead != KIND_IRQ && shadow.irq_state == ST_SUBST) shadow.irq_state = ST_PEND;
      if (lead != KIND_NMI && shadow.nmi_state == ST_SUBST) shadow.nmi_state = ST_PEND;

      shadow.trigger_at_t2 = it.branch_now && !it.page_cross_now;
      shadow.trigger_at_t0 = !shadow.trigger_at_t2;
   endfunction

   function automatic cir_result_type predict_report(input cir_item_type it);
      cir_result_type r;
      case (it.func)
         FUNC_TICK: begin
            clock_recognizers(it);
         end
         FUNC_CLEAR: begin
            case (it.clear_kind)
               KIND_RESET: shadow.rst_state = ST_IDLE;
               KIND_NMI: begin
                  shadow.nmi_state = ST_IDLE;
                  shadow.nmi_edge_held = 1'b0;
                  shadow.nmi_edge_seen = 1'b0;
               end
               KIND_IRQ: shadow.irq_state = ST_IDLE;
               default: ;
            endcase
            shadow.substitution_ready = 1'b0;
            shadow.selected_kind = KIND_NONE;
         end
         FUNC_FORCE: begin
            shadow.nmi_state = ST_IDLE;
            shadow.irq_state = ST_IDLE;
            shadow.rst_state = ST_SUBST;
            shadow.nmi_edge_seen = 1'b0;
            shadow.nmi_edge_held = 1'b0;
            shadow.selected_kind = KIND_RESET;
            shadow.substitution_ready = 1'b1;
         end
         default: ;
      endcase
      r.vector_ready = shadow.substitution_ready;
      r.vector_kind = shadow.selected_kind;
      case (shadow.selected_kind)
         KIND_RESET: r.vector_address = VEC_RESET;
         KIND_NMI:   r.vector_address = VEC_NMI;
         KIND_IRQ:   r.vector_address = VEC_IRQ;
         default:    r.vector_address = VEC_NONE;
      endcase
      r.nmi_state = shadow.nmi_state;
      r.irq_state = shadow.irq_state;
      r.rst_state = shadow.rst_state;
      r.intg_level = (shadow.nmi_state >= ST_PEND) || (shadow.irq_state >= ST_PEND);
      r.resg_level = shadow.rst_state >= ST_PEND;
      return r;
   endfunction

   task automatic compare_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s mismatch: expected %0h, got %0h", name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         shadow = '0;
         predicted_reports.delete();
      end else begin
         if (req_valid && !req_stall) begin
            incoming.func = req_func;
            incoming.nmi_pin_n = req_nmi_pin_n;
            incoming.irq_pin_n = req_irq_pin_n;
            incoming.reset_pin_n = req_reset_pin_n;
            incoming.timing_phase = req_timing_phase;
            incoming.irq_disable = req_irq_disable;
            incoming.branch_now = req_branch_now;
            incoming.page_cross_now = req_page_cross_now;
            incoming.clear_kind = req_clear_kind;
            predicted_reports.push_back(predict_report(incoming));
         end
         if (rsp_valid && !rsp_stall) begin
            if (predicted_reports.size() == 0) begin
               $error("report arrived with no item outstanding");
               mismatch_count++;
            end else begin
               wanted = predicted_reports.pop_front();
               compare_field("vector_ready", wanted.vector_ready, rsp_vector_ready);
               compare_field("vector_kind", wanted.vector_kind, rsp_vector_kind);
               compare_field("vector_address", wanted.vector_address, rsp_vector_address);
               compare_field("nmi_stage_now", wanted.nmi_state, rsp_nmi_stage_now);
               compare_field("irq_stage_now", wanted.irq_state, rsp_irq_stage_now);
               compare_field("reset_stage_now", wanted.rst_state, rsp_reset_stage_now);
               compare_field("intg_level", wanted.intg_level, rsp_intg_level);
               compare_field("resg_level", wanted.resg_level, rsp_resg_level);
            end
         end
      end
      reports_pending = predicted_reports.size();
   end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// drives the interrupt recognition block with directed pin and command items,
// then with instruction-shaped cpu cycles mixed with clears, forced resets and
// noise, under random idles, stalls and one long result hold-off
// ----------------------------------------------------------------------------
module testbench;
   import cir_pkg::*;

   localparam logic [1:0] FUNC_UNUSED = 2'd3;
   localparam logic [1:0] PH_OTHER    = 2'd0;
   localparam int         ITEM_COUNT  = 2000;
   localparam int         IDLE_LIMIT  = 2000;
   localparam int         ITEM_BITS   = $bits(cir_item_type);

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_func = FUNC_TICK;
   logic        req_nmi_pin_n = 1'b1;
   logic        req_irq_pin_n = 1'b1;
   logic        req_reset_pin_n = 1'b1;
   logic [1:0]  req_timing_phase = PH_OTHER;
   logic        req_irq_disable = 1'b0;
   logic        req_branch_now = 1'b0;
   logic        req_page_cross_now = 1'b0;
   logic [1:0]  req_clear_kind = KIND_NONE;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_vector_ready;
   logic [1:0]  rsp_vector_kind;
   logic [15:0] rsp_vector_address;
   logic [2:0]  rsp_nmi_stage_now;
   logic [2:0]  rsp_irq_stage_now;
   logic [2:0]  rsp_reset_stage_now;
   logic        rsp_intg_level;
   logic        rsp_resg_level;
   int          mismatch_count;
   int          reports_pending;

   int   items_sent = 0;
   int   quiet_cycles = 0;
   logic hold_active = 1'b0;
   wire  calm = (items_sent >= 1000) && (items_sent < 1300);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   cpu_interrupt_recognition_top dut (.*);

   recognition_checker checker_inst (.*);

   function automatic cir_item_type make_tick(input logic nmi_n, input logic irq_n,
                                              input logic rst_n, input logic [1:0] phase,
                                              input logic idis, input logic br,
                                              input logic cr);
      cir_item_type it;
      it.func = FUNC_TICK;
      it.nmi_pin_n = nmi_n;
      it.irq_pin_n = irq_n;
      it.reset_pin_n = rst_n;
      it.timing_phase = phase;
      it.irq_disable = idis;
      it.branch_now = br;
      it.page_cross_now = cr;
      it.clear_kind = KIND_NONE;
      return it;
   endfunction

   function automatic cir_item_type make_command(input logic [1:0] func,
                                                 input logic [1:0] kind);
      cir_item_type it;
      it = make_tick(1'b1, 1'b1, 1'b1, PH_OTHER, 1'b0, 1'b0, 1'b0);
      it.func = func;
      it.clear_kind = kind;
      return it;
   endfunction

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic send_item(input cir_item_type it);
      while (!calm && !hold_active && $urandom_range(99) < 25) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_func <= it.func;
      req_nmi_pin_n <= it.nmi_pin_n;
      req_irq_pin_n <= it.irq_pin_n;
      req_reset_pin_n <= it.reset_pin_n;
      req_timing_phase <= it.timing_phase;
      req_irq_disable <= it.irq_disable;
      req_branch_now <= it.branch_now;
      req_page_cross_now <= it.page_cross_now;
      req_clear_kind <= it.clear_kind;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic run_cpu_traffic(input int count);
      cir_item_type                     it;
      logic [$bits(cir_item_type)-1:0] raw;
      logic                             nmi_n;
      logic                             irq_n;
      logic                             rst_n;
      logic                             idis;
      logic                             br;
      logic                             cr;
      logic [1:0]                       phase;
      int                               instr_len;
      int                               cyc;
      int                               done;
      int                               roll;
      nmi_n = 1'b1;
      irq_n = 1'b1;
      rst_n = 1'b1;
      idis = 1'b0;
      br = 1'b0;
      cr = 1'b0;
      instr_len = 2;
      cyc = 0;
      done = 0;
      while (done < count) begin
         roll = $urandom_range(99);
         if (roll < 8) begin
            raw = ITEM_BITS'($urandom);
            it = raw;
         end else if (roll < 14) begin
            it = make_command(FUNC_CLEAR, 2'($urandom_range(3)));
         end else if (roll == 14) begin
            it = make_command(FUNC_FORCE, KIND_NONE);
         end else if (roll == 15) begin
            it = make_command(FUNC_UNUSED, 2'($urandom_range(3)));
         end else begin
            // pins drift slowly, phases follow an instruction
            if ($urandom_range(99) < 6) nmi_n = !nmi_n;
            if ($urandom_range(99) < 8) irq_n = !irq_n;
            if (rst_n ? ($urandom_range(199) == 0) : ($urandom_range(99) < 30)) rst_n = !rst_n;
            if ($urandom_range(99) < 5) idis = !idis;
            if (cyc == 0) begin
               instr_len = $urandom_range(7, 2);
               br = 1'($urandom_range(1));
               cr = 1'($urandom_range(1));
            end
            if (cyc == 0) phase = PH_T1F;
            else if (cyc == instr_len - 1) phase = PH_T0;
            else if (cyc == 1) phase = PH_T2;
            else phase = PH_OTHER;
            cyc = (cyc + 1) % instr_len;
            it = make_tick(nmi_n, irq_n, rst_n, phase, idis, br, cr);
         end
         send_item(it);
         if (it.func != FUNC_UNUSED) done++;
      end
   endtask

   initial begin
      repeat (3) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_item(make_tick(1'b1, 1'b1, 1'b1, PH_OTHER, 1'b0, 1'b0, 1'b0));
      send_item(cir_item_type'({FUNC_UNUSED, 10'h3ff}));
      // nmi edge, trigger at t0, substitute at t1f
      send_item(make_tick(1'b0, 1'b1, 1'b1, PH_OTHER, 1'b0, 1'b0, 1'b0));
      send_item(make_tick(1'b0, 1'b1, 1'b1, PH_T0, 1'b0, 1'b0, 1'b0));
      send_item(make_tick(1'b0, 1'b1, 1'b1, PH_T1F, 1'b0, 1'b0, 1'b0));
      // irq behind nmi, branch without page cross triggers at t2
      send_item(make_tick(1'b0, 1'b0, 1'b1, PH_OTHER, 1'b0, 1'b1, 1'b0));
      send_item(make_tick(1'b0, 1'b0, 1'b1, PH_T2, 1'b0, 1'b0, 1'b0));
      send_item(make_command(FUNC_CLEAR, KIND_NMI));
      send_item(make_tick(1'b1, 1'b0, 1'b1, PH_T1F, 1'b0, 1'b0, 1'b0));
      // reset pin demotes the substituted irq
      send_item(make_tick(1'b1, 1'b0, 1'b0, PH_OTHER, 1'b0, 1'b0, 1'b1));
      send_item(make_tick(1'b1, 1'b0, 1'b0, PH_T0, 1'b0, 1'b0, 1'b0));
      send_item(make_tick(1'b1, 1'b0, 1'b0, PH_T1F, 1'b0, 1'b0, 1'b0));
      send_item(make_command(FUNC_CLEAR, KIND_NONE));
      send_item(make_command(FUNC_CLEAR, KIND_RESET));
      send_item(make_command(FUNC_CLEAR, KIND_IRQ));
      send_item(make_command(FUNC_FORCE, KIND_NONE));
      // masked irq falls back to idle
      send_item(make_tick(1'b1, 1'b0, 1'b1, PH_OTHER, 1'b1, 1'b0, 1'b0));
      send_item(make_tick(1'b0, 1'b1, 1'b1, PH_OTHER, 1'b0, 1'b0, 1'b0));
      send_item(make_command(FUNC_CLEAR, KIND_RESET));
      send_item(make_tick(1'b1, 1'b1, 1'b1, PH_T1F, 1'b1, 1'b1, 1'b1));
      send_item(make_tick(1'b0, 1'b0, 1'b0, PH_OTHER, 1'b0, 1'b0, 1'b0));

      run_cpu_traffic(ITEM_COUNT);
      req_valid <= 1'b0;

      while (reports_pending != 0) @(negedge clock);
      repeat (10) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin
      int   hold_left;
      logic hold_done;
      hold_left = 0;
      hold_done = 1'b0;
      forever begin
         @(negedge clock);
         if (!hold_done && items_sent >= 500) begin
            hold_done = 1'b1;
            hold_left = 60;
         end
         hold_active <= (hold_left > 0);
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !calm && ($urandom_range(99) < 25);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= IDLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule
